// ===== rtl/core/ambient_dimmer_controller_macros.svh =====
// ---------------------------------------------------------------------------
// Ambient dimmer controller assertion macros
// Shorthand for the clocked, reset-qualified checks of the dimmer design.
// ---------------------------------------------------------------------------
`ifndef AMBIENT_DIMMER_CONTROLLER_MACROS_SVH
`define AMBIENT_DIMMER_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ADC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ADC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/adc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ambient dimmer controller package
// Item types, level constants and the ambient light band lookup.
// ---------------------------------------------------------------------------
package adc_pkg;

	typedef logic [3:0] level_t;

	typedef struct packed {
		logic       mode_press;
		logic       down_press;
		logic       up_press;
		logic       sample_valid;
		logic [7:0] ambient_level;
		logic       presence;
	} item_t;

	typedef struct packed {
		logic   lamp_on;
		level_t level_now;
		logic   in_auto;
		logic   absent_off;
	} result_t;

	typedef struct packed {
		logic   hit;
		level_t level;
	} band_t;

	localparam level_t LevelOff = 4'd0;
	localparam level_t LevelMax = 4'd9;

	localparam logic [7:0] DarkBelow   = 8'd60;
	localparam logic [7:0] BandLo0     = 8'd66;
	localparam logic [7:0] BandWidth   = 8'd16;
	localparam logic [7:0] BandStep    = 8'd22;
	localparam logic [7:0] BrightAbove = 8'd242;
	localparam int         NumBands    = 8;

	localparam logic [15:0] AbsenceLimitReset = 16'd60000;
	localparam logic [16:0] CountMax          = 17'h1FFFF;

	// Maps an ambient reading to a level. Readings in the gaps between bands
	// report no hit, so the caller keeps its current level.
	function automatic band_t band_lookup(input logic [7:0] v);
		band_t      r;
		logic [7:0] lo;
		r.hit   = 1'b0;
		r.level = LevelOff;
		if (v < DarkBelow) begin
			r.hit   = 1'b1;
			r.level = LevelMax;
		end
		if (v > BrightAbove) begin
			r.hit   = 1'b1;
			r.level = LevelOff;
		end
		for (int k = 0; k < NumBands; k++) begin
			lo = 8'(BandLo0 + BandStep * k);
			if (v > lo && v < 8'(lo + BandWidth)) begin
				r.hit   = 1'b1;
				r.level = 4'(NumBands - k);
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/adc_item_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dimmer input item channel
// One tick of key presses, ambient sample and presence with valid/ready.
// ---------------------------------------------------------------------------
interface adc_item_if;
	logic       valid;
	logic       ready;
	logic       mode_press;
	logic       down_press;
	logic       up_press;
	logic       sample_valid;
	logic [7:0] ambient_level;
	logic       presence;

	modport source (
		output valid, mode_press, down_press, up_press, sample_valid, ambient_level, presence,
		input  ready
	);
	modport sink (
		input  valid, mode_press, down_press, up_press, sample_valid, ambient_level, presence,
		output ready
	);
endinterface

// ===== rtl/core/adc_result_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dimmer result item channel
// Lamp drive, level, mode and absence status with valid/ready.
// ---------------------------------------------------------------------------
interface adc_result_if;
	logic       valid;
	logic       ready;
	logic       lamp_on;
	logic [3:0] level_now;
	logic       in_auto;
	logic       absent_off;

	modport source (
		output valid, lamp_on, level_now, in_auto, absent_off,
		input  ready
	);
	modport sink (
		input  valid, lamp_on, level_now, in_auto, absent_off,
		output ready
	);
endinterface

// ===== rtl/core/adc_cfg_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dimmer configuration write channel
// Carries the absence limit write data with valid/ready.
// ---------------------------------------------------------------------------
interface adc_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/ambient_dimmer_controller.sv =====
`timescale 1ns / 1ps
// An item is taken into the input register when accepted; when the input stage advances,
// its result is written into the result register and shown on the result port.
// Throughput is one item per clock while the result port is not stalled, bounded by the
// combinational state update between the two registers. Reset (arst_n low, asynchronous)
// clears both stages, sets auto mode, level 0, PWM phase 0, absence count 0, lamp off,
// and loads the absence limit with 60000. The block takes items right after reset.
// ---------------------------------------------------------------------------
// Ambient dimmer controller
// Auto/manual lamp level control with a PWM lamp drive and an absence timeout.
// ---------------------------------------------------------------------------
`include "ambient_dimmer_controller_macros.svh"

module ambient_dimmer_controller import adc_pkg::*; #(
	parameter int PWM_SLOTS = 10
) (
	input  logic clk,
	input  logic arst_n,
	adc_cfg_if.sink      cfg,
	adc_item_if.sink     item,
	adc_result_if.source result
);

	// The phase counter holds 0 .. PWM_SLOTS-1. The increment is one bit wider
	// so that it can reach PWM_SLOTS before it wraps.
	localparam int PhaseW = $clog2(PWM_SLOTS);
	localparam int CmpW   = (PhaseW > 4) ? PhaseW : 4;
	localparam logic [PhaseW:0] SlotCount = (PhaseW + 1)'(PWM_SLOTS);

	// Configuration register. Writes must arrive only while the block is idle (the block
	// itself does not enforce this); the port is always ready.
	logic [15:0] absence_limit_q;

	// Input stage.
	logic  valid_s1;
	item_t item_s1;

	// Result register.
	logic    out_valid_q;
	result_t out_q;

	// Controller state.
	level_t              brightness_q;
	logic                manual_q;
	logic [PhaseW-1:0]   phase_q;
	logic [16:0]         count_q;
	logic                drive_q;

	// Next-state values for the item in the input stage.
	level_t              level_n;
	logic                manual_n;
	logic [PhaseW-1:0]   phase_n;
	logic [PhaseW:0]     phase_inc;
	logic [16:0]         count_n;
	logic [16:0]         limit_ext;
	logic                drive_n;
	band_t               band;
	item_t               item_in;

	// The input stage hands its item on whenever the result register is empty
	// or being drained this cycle. That keeps a new item flowing every clock
	// while the result port takes each finished result that waits downstream.
	logic advance;

	assign cfg.ready = 1'b1;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	assign item_in.mode_press    = item.mode_press;
	assign item_in.down_press    = item.down_press;
	assign item_in.up_press      = item.up_press;
	assign item_in.sample_valid  = item.sample_valid;
	assign item_in.ambient_level = item.ambient_level;
	assign item_in.presence      = item.presence;

	assign result.valid      = out_valid_q;
	assign result.lamp_on    = out_q.lamp_on;
	assign result.level_now  = out_q.level_now;
	assign result.in_auto    = out_q.in_auto;
	assign result.absent_off = out_q.absent_off;

	assign band      = band_lookup(item_s1.ambient_level);
	assign limit_ext = {1'b0, absence_limit_q};

	// One tick of the controller, in the order the behavior defines: mode key,
	// manual steps or auto band map, presence, absence clamp, absence count,
	// and finally the PWM phase and lamp drive.
	always_comb begin
		manual_n = manual_q ^ item_s1.mode_press;
		level_n  = brightness_q;

		// Returning to auto mode applies a valid sample right away.
		if (item_s1.mode_press && !manual_n && item_s1.sample_valid && band.hit) begin
			level_n = band.level;
		end

		if (manual_n) begin
			if (item_s1.down_press && level_n != LevelOff) begin
				level_n = level_n - 4'd1;
			end
			if (item_s1.up_press && level_n != LevelMax) begin
				level_n = level_n + 4'd1;
			end
		end else if (count_q < limit_ext && item_s1.sample_valid && band.hit) begin
			level_n = band.level;
		end

		count_n = item_s1.presence ? 17'd0 : count_q;

		// Past the limit the level is forced off and the count held at the
		// limit, so that the increment of an auto tick pushes it past again.
		if (count_n > limit_ext) begin
			count_n = limit_ext;
			level_n = LevelOff;
		end

		if (!manual_n && count_n != CountMax) begin
			count_n = count_n + 17'd1;
		end

		// The drive turns on at the wrap of the phase unless the level is off, and
		// off when the phase meets the level. Full level never turns off.
		drive_n   = drive_q;
		phase_inc = {1'b0, phase_q} + (PhaseW + 1)'(1);
		if (phase_inc >= SlotCount) begin
			phase_n = '0;
			if (level_n != LevelOff) begin
				drive_n = 1'b1;
			end
		end else begin
			phase_n = phase_inc[PhaseW-1:0];
		end
		if (CmpW'(phase_n) == CmpW'(level_n) && level_n != LevelMax) begin
			drive_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			absence_limit_q <= AbsenceLimitReset;
			valid_s1        <= 1'b0;
			out_valid_q     <= 1'b0;
			brightness_q    <= LevelOff;
			manual_q        <= 1'b0;
			phase_q         <= '0;
			count_q         <= '0;
			drive_q         <= 1'b0;
		end else begin
			if (cfg.valid) begin
				absence_limit_q <= cfg.data;
			end
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (advance) begin
				out_valid_q  <= 1'b1;
				brightness_q <= level_n;
				manual_q     <= manual_n;
				phase_q      <= phase_n;
				count_q      <= count_n;
				drive_q      <= drive_n;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset; their valid bits guard them.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item_in;
		end
		if (advance) begin
			out_q.lamp_on    <= drive_n;
			out_q.level_now  <= level_n;
			out_q.in_auto    <= !manual_n;
			out_q.absent_off <= (count_n > limit_ext);
		end
	end

	// An item that leaves the input stage must appear as a result next cycle.
	`ADC_ASSERT_NEXT(a_advance_to_result, advance, result.valid, "item lost between stages")
	// An empty input stage must always take an item.
	`ADC_ASSERT_NOW(a_ready_when_empty, !valid_s1, item.ready, "input stalled while empty")
	// The level never leaves its range.
	`ADC_ASSERT_NOW(a_level_range, 1'b1, brightness_q <= LevelMax, "level out of range")
	// The phase counter stays below the slot count.
	`ADC_ASSERT_NOW(a_phase_range, 1'b1, {1'b0, phase_q} < SlotCount, "PWM phase out of range")

endmodule

// ===== tb/ambient_dimmer_controller_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ambient dimmer controller checker
// Watches the configuration, tick and result channels, predicts each lamp
// result from its own dimmer state and compares it field by field.
// ---------------------------------------------------------------------------
module ambient_dimmer_controller_checker import adc_pkg::*; #(
	parameter int PWM_SLOTS = 10
) (
	input  logic  clk,
	input  logic  arst_n,
	adc_cfg_if    cfg,
	adc_item_if   item,
	adc_result_if result,
	output int    errors,
	output int    pending,
	output int    forced_off_count
);

	localparam logic [7:0] DarkEdge   = 8'd60;
	localparam logic [7:0] BrightEdge = 8'd242;
	localparam int         FirstLo    = 66;
	localparam int         BandPitch  = 22;
	localparam int         BandSpan   = 16;
	localparam int         Bands      = 8;
	localparam logic [16:0] AwayMax   = 17'h1FFFF;

	// Predicted dimmer state.
	logic [15:0] away_limit;
	level_t      lvl;
	logic        manual;
	int unsigned slot;
	logic [16:0] away;
	logic        lamp;

	result_t due_lamp_q[$];

	// Level picked by an ambient reading; readings between bands keep the level.
	function automatic level_t light_band(input logic [7:0] v, input level_t keep);
		level_t pick;
		int     lo;
		pick = keep;
		if (v < DarkEdge) begin
			pick = LevelMax;
		end else if (v > BrightEdge) begin
			pick = LevelOff;
		end else begin
			for (int b = 0; b < Bands; b++) begin
				lo = FirstLo + BandPitch * b;
				if (int'(v) > lo && int'(v) < lo + BandSpan) begin
					pick = level_t'(Bands - b);
				end
			end
		end
		return pick;
	endfunction

	// Advances the predicted state by one tick and returns the result it shows.
	function automatic result_t advance_dimmer(input item_t t);
		result_t r;
		if (t.mode_press) begin
			manual = !manual;
			if (!manual && t.sample_valid) begin
				lvl = light_band(t.ambient_level, lvl);
			end
		end
		if (manual) begin
			if (t.down_press && lvl != LevelOff) begin
				lvl = lvl - 1'b1;
			end
			if (t.up_press && lvl != LevelMax) begin
				lvl = lvl + 1'b1;
			end
		end else if (away < {1'b0, away_limit} && t.sample_valid) begin
			lvl = light_band(t.ambient_level, lvl);
		end
		if (t.presence) begin
			away = '0;
		end
		if (away > {1'b0, away_limit}) begin
			away = {1'b0, away_limit};
			lvl  = LevelOff;
		end
		if (!manual && away != AwayMax) begin
			away = away + 1'b1;
		end
		slot = slot + 1;
		if (slot >= PWM_SLOTS) begin
			slot = 0;
			if (lvl != LevelOff) begin
				lamp = 1'b1;
			end
		end
		if (slot == lvl && lvl != LevelMax) begin
			lamp = 1'b0;
		end
		r.lamp_on    = lamp;
		r.level_now  = lvl;
		r.in_auto    = !manual;
		r.absent_off = away > {1'b0, away_limit};
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		item_t   tick;
		result_t want;
		if (!arst_n) begin
			away_limit = AbsenceLimitReset;
			lvl        = LevelOff;
			manual     = 1'b0;
			slot       = 0;
			away       = '0;
			lamp       = 1'b0;
			due_lamp_q.delete();
			errors           = 0;
			forced_off_count = 0;
			pending         <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				away_limit = cfg.data;
			end
			if (item.valid && item.ready) begin
				tick.mode_press    = item.mode_press;
				tick.down_press    = item.down_press;
				tick.up_press      = item.up_press;
				tick.sample_valid  = item.sample_valid;
				tick.ambient_level = item.ambient_level;
				tick.presence      = item.presence;
				due_lamp_q.push_back(advance_dimmer(tick));
			end
			if (result.valid && result.ready) begin
				if (due_lamp_q.size() == 0) begin
					$error("result item arrived with no tick waiting for it");
					errors++;
				end else begin
					want = due_lamp_q.pop_front();
					if (want.absent_off) begin
						forced_off_count++;
					end
					if (result.lamp_on !== want.lamp_on) begin
						$error("lamp_on: expected %0d, actual %0d", want.lamp_on,
							result.lamp_on);
						errors++;
					end
					if (result.level_now !== want.level_now) begin
						$error("level_now: expected %0d, actual %0d", want.level_now,
							result.level_now);
						errors++;
					end
					if (result.in_auto !== want.in_auto) begin
						$error("in_auto: expected %0d, actual %0d", want.in_auto,
							result.in_auto);
						errors++;
					end
					if (result.absent_off !== want.absent_off) begin
						$error("absent_off: expected %0d, actual %0d", want.absent_off,
							result.absent_off);
						errors++;
					end
				end
			end
			pending <= due_lamp_q.size();
		end
	end

endmodule

// ===== tb/ambient_dimmer_controller_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ambient dimmer controller testbench
// Drives directed and random millisecond ticks through the dimmer under
// bursty input and stalling output, across several absence limits, while
// the checker predicts and compares every result item.
// ---------------------------------------------------------------------------
module ambient_dimmer_controller_test import adc_pkg::*; ();

	localparam int PWM_SLOTS     = 10;
	localparam int NumPhases     = 8;
	localparam int TicksPerPhase = 95;
	// The block passes a tick through its input stage and result register; the
	// settle cycles cover that before a register write and at the end of the run.
	localparam int SettleCycles  = 4;
	// The watchdog limit lies far above the length of the slowest legal run.
	localparam int CycleLimit    = 200000;

	logic clk = 1'b0;
	logic arst_n;

	int errors;
	int pending;
	int forced_off_count;
	int cycles         = 0;
	int ticks_sent     = 0;
	int limits_written = 0;

	// Sender burst bookkeeping and the receiver's rotating stall pattern.
	int unsigned burst_left = 0;
	logic [31:0] stall_bits = '1;
	int          stall_age  = 0;

	// Absence limits for the random phases. Both extremes appear, the small
	// values let the absence timeout fire often, and one entry is redrawn at
	// random when its phase starts.
	int unsigned limit_table [NumPhases] = '{0, 3, 65535, 1, 12, 0, 40, 7};

	adc_cfg_if    cfg ();
	adc_item_if   item ();
	adc_result_if result ();

	ambient_dimmer_controller #(.PWM_SLOTS(PWM_SLOTS)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.result (result)
	);

	ambient_dimmer_controller_checker #(.PWM_SLOTS(PWM_SLOTS)) lamp_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.item             (item),
		.result           (result),
		.errors           (errors),
		.pending          (pending),
		.forced_off_count (forced_off_count)
	);

	always #10 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles == CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// The receiver reloads a 32-bit stall pattern each time the previous
	// one has rotated through. Some patterns are fully open, some random,
	// some mostly ready and some hold off for long stretches.
	always @(posedge clk) begin
		if (stall_age == 0) begin
			case ($urandom_range(0, 3))
				0: begin
					stall_bits = '1;
				end
				1: begin
					stall_bits = $urandom;
				end
				2: begin
					stall_bits = $urandom | $urandom;
				end
				default: begin
					stall_bits = 32'h0000_0FFF;
				end
			endcase
			stall_age = 32;
		end
		result.ready <= stall_bits[0];
		stall_bits = {stall_bits[0], stall_bits[31:1]};
		stall_age  = stall_age - 1;
	end

	// Offers one tick and returns at the edge where it is taken. Ticks go
	// out in bursts; between bursts valid usually drops for a random gap. Valid is
	// only ever driven once per time step.
	task automatic send_tick(input item_t t);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				item.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		item.valid         <= 1'b1;
		item.mode_press    <= t.mode_press;
		item.down_press    <= t.down_press;
		item.up_press      <= t.up_press;
		item.sample_valid  <= t.sample_valid;
		item.ambient_level <= t.ambient_level;
		item.presence      <= t.presence;
		@(posedge clk);
		while (!item.ready) @(posedge clk);
		burst_left = burst_left - 1;
		ticks_sent++;
	endtask

	// Directed ticks are written out field by field.
	task automatic drive_tick(input logic m, input logic d, input logic u,
			input logic sv, input logic [7:0] amb, input logic p);
		item_t t;
		t.mode_press    = m;
		t.down_press    = d;
		t.up_press      = u;
		t.sample_valid  = sv;
		t.ambient_level = amb;
		t.presence      = p;
		send_tick(t);
	endtask

	// Random tick. Mode presses are sparse so that auto and manual stretches
	// last a while; half the readings are uniform over the whole range and
	// the rest sit right on the band edges.
	function automatic item_t random_tick(input int unsigned presence_pct);
		item_t       t;
		int unsigned pick;
		int unsigned band;
		pick = $urandom_range(0, 9);
		band = $urandom_range(0, 7);
		t.mode_press   = $urandom_range(0, 99) < 6;
		t.down_press   = $urandom_range(0, 99) < 35;
		t.up_press     = $urandom_range(0, 99) < 35;
		t.sample_valid = $urandom_range(0, 99) < 75;
		t.presence     = $urandom_range(0, 99) < presence_pct;
		if (pick < 5) begin
			t.ambient_level = 8'($urandom);
		end else if (pick < 9) begin
			// Low edge of a band is lo and lo + 1, high edge lo + 15 and lo + 16.
			t.ambient_level = 8'(66 + 22 * band + ($urandom_range(0, 1) ?
				$urandom_range(0, 1) : 15 + $urandom_range(0, 1)));
		end else begin
			t.ambient_level = 8'($urandom_range(0, 1) ?
				59 + $urandom_range(0, 1) : 242 + $urandom_range(0, 1));
		end
		return t;
	endfunction

	// Waits until every expected result has come back. The first edge lets
	// the checker count a tick that was taken at the edge we were called on.
	task automatic wait_for_results();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Writes the absence limit once the block is idle: no tick in flight,
	// every result delivered and the pipeline given time to settle.
	task automatic write_limit(input logic [15:0] v);
		item.valid <= 1'b0;
		burst_left = 0;
		wait_for_results();
		repeat (SettleCycles) @(posedge clk);
		cfg.data  <= v;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		limits_written++;
	endtask

	initial begin
		// Every input is known from time zero, while reset is held low.
		arst_n             = 1'b0;
		cfg.valid          = 1'b0;
		cfg.data           = '0;
		item.valid         = 1'b0;
		item.mode_press    = 1'b0;
		item.down_press    = 1'b0;
		item.up_press      = 1'b0;
		item.sample_valid  = 1'b0;
		item.ambient_level = '0;
		item.presence      = 1'b0;
		result.ready       = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, under the reset absence limit.
		// A reading without its valid flag is ignored.
		drive_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'd255, 1'b0);
		// Darkest readings give full level; the gap above them keeps it.
		drive_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'd0,   1'b0);
		drive_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'd59,  1'b0);
		drive_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'd60,  1'b0);
		// Into manual mode with an up press at full level: it saturates.
		drive_tick(1'b1, 1'b0, 1'b1, 1'b1, 8'd0,   1'b0);
		// Both keys at once: down first, then up.
		drive_tick(1'b0, 1'b1, 1'b1, 1'b0, 8'd0,   1'b0);
		drive_tick(1'b0, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0);
		// Back to auto with a valid bright reading: the band map applies at once.
		drive_tick(1'b1, 1'b0, 1'b0, 1'b1, 8'd243, 1'b0);
		// Manual again; down at level 0 saturates and the reading is ignored.
		drive_tick(1'b1, 1'b1, 1'b0, 1'b1, 8'd0,   1'b0);
		drive_tick(1'b0, 1'b0, 1'b1, 1'b0, 8'd0,   1'b1);
		// Entering auto without a sample keeps the manual level.
		drive_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0);
		// Walk across band edges and the gaps between them.
		drive_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'd66,  1'b0);
		drive_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'd67,  1'b0);
		drive_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'd81,  1'b0);
		drive_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'd82,  1'b0);
		drive_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'd89,  1'b0);
		drive_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'd235, 1'b0);
		drive_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'd236, 1'b0);
		drive_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'd242, 1'b0);
		drive_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'd243, 1'b0);
		// Every field at its top value, then back to auto in a middle band.
		drive_tick(1'b1, 1'b1, 1'b1, 1'b1, 8'd255, 1'b1);
		drive_tick(1'b1, 1'b0, 1'b0, 1'b1, 8'd140, 1'b0);
		// Keys do nothing in auto mode.
		drive_tick(1'b0, 1'b1, 1'b1, 1'b1, 8'd140, 1'b1);

		// Random phases. Each starts from an idle block with a new absence
		// limit; odd phases rarely see presence so the lamp gets forced off
		// and held, even phases see it often enough to keep clearing the count.
		for (int ph = 0; ph < NumPhases; ph++) begin
			if (ph == 5) begin
				write_limit(16'($urandom_range(0, 30)));
			end else begin
				write_limit(16'(limit_table[ph]));
			end
			repeat (TicksPerPhase) send_tick(random_tick((ph % 2 == 1) ? 2 : 20));
		end

		item.valid <= 1'b0;
		wait_for_results();
		repeat (SettleCycles) @(posedge clk);

		$display("Sent %0d ticks over %0d absence-limit settings with %0d PWM slots.",
			ticks_sent, limits_written, PWM_SLOTS);
		$display("%0d results showed the absence timeout; %0d field mismatches.",
			forced_off_count, errors);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
